[src/gkdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gkdm_pkg;

   localparam int KMER_LEN_DEF   = 10;
   localparam int COUNT_BITS_DEF = 32;

   localparam int ENTRY_CODE_W   = 20;
   localparam int BASE_CHAR_W    = 8;
   localparam int MATCH_COUNT_W  = 32;

   // presence map rows: 64 bits per row, low code bits select the bit
   localparam int MAP_WORD_BITS  = 64;
   localparam int WORD_IDX_W     = 6;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_CHAR = 1'b1;

   localparam logic [BASE_CHAR_W-1:0] CHAR_A = 8'h41;
   localparam logic [BASE_CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [BASE_CHAR_W-1:0] CHAR_G = 8'h47;
   localparam logic [BASE_CHAR_W-1:0] CHAR_T = 8'h54;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic                    kind;
      logic [ENTRY_CODE_W-1:0] entry_code;
      logic [BASE_CHAR_W-1:0]  base_char;
      logic                    segment_start;
   } req_word_type;

   typedef struct packed {
      logic                     match_found;
      logic [MATCH_COUNT_W-1:0] match_count;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } base_type;

   function automatic base_type base_decode(logic [BASE_CHAR_W-1:0] ch);
      base_type b;
      b.valid = 1'b1;
      b.code  = BASE_A;
      case (ch)
         CHAR_A: b.code = BASE_A;
         CHAR_C: b.code = BASE_C;
         CHAR_G: b.code = BASE_G;
         CHAR_T: b.code = BASE_T;
         default: b.valid = 1'b0;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

[src/greedy_kmer_dictionary_matcher_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Greedy non-overlapping k-mer dictionary matcher.
// Request channel (req_valid / req_stall / req_word): kind selects a dictionary
// load (entry_code sets that k-mer in the presence map) or one sequence
// character (base_char, segment_start). Every request word yields exactly one
// response word on rsp_valid / rsp_stall / rsp_word: match_found and the
// running saturating match count.
// The synchronous presence map read and the lookup stage are registered at
// acceptance; the hit decision follows from the read data and is registered
// in the response register, which drives rsp_valid.
// One word per cycle is taken while req_stall is low; loads read-modify-write a
// 64-bit map row, with the write forwarded to a read of the same row.
// After reset the map is swept clear one row per cycle, all 2^(2*KMER_LEN-6)
// rows (16384 at KMER_LEN = 10); req_stall stays high meanwhile.
// When the receiver stalls, the response register holds and req_stall rises
// as soon as the one item in the lookup stage has nowhere to go.
module greedy_kmer_dictionary_matcher_unit #(
   parameter int KMER_LEN   = gkdm_pkg::KMER_LEN_DEF,
   parameter int COUNT_BITS = gkdm_pkg::COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire gkdm_pkg::req_word_type req_word,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      gkdm_pkg::rsp_word_type rsp_word
);

   localparam int CODE_W = 2 * KMER_LEN;
   localparam int IDX_W  = gkdm_pkg::WORD_IDX_W;
   localparam int ROW_W  = CODE_W - IDX_W;
   localparam int FILL_W = $clog2(KMER_LEN + 1);
   localparam int DW     = gkdm_pkg::MAP_WORD_BITS;
   localparam int OUT_W  = gkdm_pkg::MATCH_COUNT_W;
   localparam int EXT_W  = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

   logic [CODE_W-1:0]     win_ff, win_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [COUNT_BITS-1:0] hit_total_ff, hit_total_in;

   logic                  s1_valid_ff;
   logic                  s1_load_ff;
   logic                  s1_lookup_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [IDX_W-1:0]      s1_idx_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   gkdm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  out_free, advance, accept, s1_done, hit;
   logic                  map_busy;
   logic [DW-1:0]         map_rd_data;
   logic [DW-1:0]         map_wr_data;
   logic                  map_wr_en;
   logic [ROW_W-1:0]      rd_row;

   logic [CODE_W-1:0]     base_win, shift_win, entry_ext;
   logic [FILL_W-1:0]     base_fill, new_fill;
   logic                  lookup_in;
   gkdm_pkg::base_type    base;
   logic [EXT_W-1:0]      count_ext;

   gkdm_map #(
      .KMER_LEN (KMER_LEN)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_row  (rd_row),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_row  (s1_row_ff),
      .wr_data (map_wr_data),
      .busy    (map_busy)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = !s1_valid_ff || out_free;
      req_stall = !advance || map_busy;
      accept    = req_valid && !req_stall;
      s1_done   = s1_valid_ff && out_free;

      hit         = s1_valid_ff && s1_lookup_ff && map_rd_data[s1_idx_ff];
      map_wr_en   = s1_done && s1_load_ff;
      map_wr_data = map_rd_data | (DW'(1) << s1_idx_ff);

      // a hit in the lookup stage restarts the window under the next word
      base_win  = (s1_done && hit) ? '0 : win_ff;
      base_fill = (s1_done && hit) ? '0 : fill_ff;

      base      = gkdm_pkg::base_decode(req_word.base_char);
      if (req_word.segment_start) begin
         base_win  = '0;
         base_fill = '0;
      end
      shift_win = {base_win[CODE_W-3:0], base.code};
      new_fill  = (base_fill < FILL_W'(KMER_LEN)) ? base_fill + FILL_W'(1) : base_fill;
      entry_ext = CODE_W'(req_word.entry_code);

      win_in    = (s1_done && hit) ? '0 : win_ff;
      fill_in   = (s1_done && hit) ? '0 : fill_ff;
      lookup_in = 1'b0;
      rd_row    = entry_ext[CODE_W-1:IDX_W];
      if (accept && req_word.kind == gkdm_pkg::KIND_CHAR) begin
         if (base.valid) begin
            win_in    = shift_win;
            fill_in   = new_fill;
            lookup_in = (new_fill >= FILL_W'(KMER_LEN));
            rd_row    = shift_win[CODE_W-1:IDX_W];
         end else begin
            win_in  = '0;
            fill_in = '0;
         end
      end

      hit_total_in = hit_total_ff;
      if (s1_done && hit && (hit_total_ff != {COUNT_BITS{1'b1}})) begin
         hit_total_in = hit_total_ff + COUNT_BITS'(1);
      end
      count_ext = EXT_W'(hit_total_in);

      rsp_word_in.match_found = hit;
      rsp_word_in.match_count = count_ext[OUT_W-1:0];

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fill_ff      <= '0;
         hit_total_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         hit_total_ff <= hit_total_in;
         if (advance) begin
            s1_valid_ff <= accept;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_load_ff   <= (req_word.kind == gkdm_pkg::KIND_LOAD);
         s1_lookup_ff <= lookup_in;
         s1_row_ff    <= rd_row;
         s1_idx_ff    <= (req_word.kind == gkdm_pkg::KIND_LOAD) ?
                         entry_ext[IDX_W-1:0] : shift_win[IDX_W-1:0];
      end
      if (s1_done) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

[src/gkdm_map.sv]
`timescale 1ns / 1ps
`default_nettype none
module gkdm_map #(
   parameter int KMER_LEN = gkdm_pkg::KMER_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                rd_en,
   input  wire logic [2*KMER_LEN-gkdm_pkg::WORD_IDX_W-1:0] rd_row,
   output      logic [gkdm_pkg::MAP_WORD_BITS-1:0]  rd_data,
   input  wire logic                                wr_en,
   input  wire logic [2*KMER_LEN-gkdm_pkg::WORD_IDX_W-1:0] wr_row,
   input  wire logic [gkdm_pkg::MAP_WORD_BITS-1:0]  wr_data,
   output      logic                                busy
);

   localparam int ROW_W = 2 * KMER_LEN - gkdm_pkg::WORD_IDX_W;
   localparam int ROWS  = 1 << ROW_W;
   localparam int DW    = gkdm_pkg::MAP_WORD_BITS;

   logic [DW-1:0]    mem [ROWS];
   logic [DW-1:0]    rd_q_ff;
   logic             fwd_valid_ff;
   logic [DW-1:0]    fwd_data_ff;
   logic             clr_busy_ff;
   logic [ROW_W-1:0] clr_row_ff;

   logic             mem_we;
   logic [ROW_W-1:0] mem_waddr;
   logic [DW-1:0]    mem_wdata;

   always_comb begin
      mem_we    = clr_busy_ff | wr_en;
      mem_waddr = clr_busy_ff ? clr_row_ff : wr_row;
      mem_wdata = clr_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_row];
      end
   end

   // a write in the read cycle to the same row is not seen by the array read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_valid_ff <= wr_en && (wr_row == rd_row);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_ff + ROW_W'(1);
         if (clr_row_ff == {ROW_W{1'b1}}) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign rd_data = fwd_valid_ff ? fwd_data_ff : rd_q_ff;
   assign busy    = clr_busy_ff;

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int KMER_LEN       = gkdm_pkg::KMER_LEN_DEF;
   localparam int CLEAR_CYCLES   = 1 << (2 * KMER_LEN - gkdm_pkg::WORD_IDX_W);
   localparam int WATCHDOG_LIMIT = 4 * CLEAR_CYCLES;
   localparam int DRAIN_CYCLES   = 8;
   localparam int ECW            = gkdm_pkg::ENTRY_CODE_W;
   localparam int BCW            = gkdm_pkg::BASE_CHAR_W;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   gkdm_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   gkdm_pkg::rsp_word_type rsp_word;

   // predictor state
   bit                                 kmer_present [logic [ECW-1:0]];
   logic [2*KMER_LEN-1:0]              window_code = '0;
   int                                 window_fill = 0;
   logic [gkdm_pkg::MATCH_COUNT_W-1:0] match_total = '0;

   gkdm_pkg::rsp_word_type   pending_matches [$];
   logic [ECW-1:0]           dict_codes [$];
   int                       error_count = 0;
   int                       words_sent = 0;
   int                       quiet_cycles = 0;
   int                       send_idle_pct = 20;
   int                       recv_idle_pct = 77;

   greedy_kmer_dictionary_matcher_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   function automatic logic [BCW-1:0] char_of_base(logic [1:0] b);
      case (b)
         gkdm_pkg::BASE_A: return gkdm_pkg::CHAR_A;
         gkdm_pkg::BASE_C: return gkdm_pkg::CHAR_C;
         gkdm_pkg::BASE_G: return gkdm_pkg::CHAR_G;
         default:          return gkdm_pkg::CHAR_T;
      endcase
   endfunction

   function automatic void window_restart();
      window_code = '0;
      window_fill = 0;
   endfunction

   function automatic gkdm_pkg::rsp_word_type predict_match(gkdm_pkg::req_word_type w);
      gkdm_pkg::rsp_word_type r;
      logic [1:0]             b;
      logic                   is_base;
      r.match_found = 1'b0;
      if (w.kind == gkdm_pkg::KIND_LOAD) begin
         kmer_present[w.entry_code] = 1'b1;
      end else begin
         if (w.segment_start) window_restart();
         is_base = 1'b1;
         b = gkdm_pkg::BASE_A;
         case (w.base_char)
            gkdm_pkg::CHAR_A: b = gkdm_pkg::BASE_A;
            gkdm_pkg::CHAR_C: b = gkdm_pkg::BASE_C;
            gkdm_pkg::CHAR_G: b = gkdm_pkg::BASE_G;
            gkdm_pkg::CHAR_T: b = gkdm_pkg::BASE_T;
            default:          is_base = 1'b0;
         endcase
         if (!is_base) begin
            window_restart();
         end else begin
            window_code = {window_code[2*KMER_LEN-3:0], b};
            if (window_fill < KMER_LEN) window_fill++;
            if (window_fill >= KMER_LEN && kmer_present.exists(window_code)) begin
               r.match_found = 1'b1;
               if (match_total != '1) match_total++;
               window_restart();
            end
         end
      end
      r.match_count = match_total;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // expectations are queued before the check so ordering within the edge is moot
   always @(posedge clock) begin
      gkdm_pkg::rsp_word_type want;
      if (!reset && req_valid && !req_stall)
         pending_matches = {pending_matches, predict_match(req_word)};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_matches.size() == 0) begin
            report_mismatch("unexpected response word", '0, rsp_word.match_count);
         end else begin
            want = pending_matches.pop_front();
            if (rsp_word.match_found !== want.match_found)
               report_mismatch("match_found", 32'(want.match_found),
                               32'(rsp_word.match_found));
            if (rsp_word.match_count !== want.match_count)
               report_mismatch("match_count", want.match_count, rsp_word.match_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(input gkdm_pkg::req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_load(input logic [ECW-1:0] code,
                            input logic [BCW-1:0] ch, input logic seg);
      gkdm_pkg::req_word_type w;
      w.kind          = gkdm_pkg::KIND_LOAD;
      w.entry_code    = code;
      w.base_char     = ch;
      w.segment_start = seg;
      dict_codes      = {dict_codes, code};
      send_word(w);
   endtask

   task automatic send_char(input logic [BCW-1:0] ch, input logic seg);
      gkdm_pkg::req_word_type w;
      w.kind          = gkdm_pkg::KIND_CHAR;
      w.entry_code    = ECW'($urandom_range(20'hFFFFF));
      w.base_char     = ch;
      w.segment_start = seg;
      send_word(w);
   endtask

   task automatic test_dictionary_load();
      send_load('0, 8'hFF, 1'b1);
      send_load('1, 8'h00, 1'b0);
      send_load('0, gkdm_pkg::CHAR_G, 1'b0);     // repeat load, no effect
   endtask

   task automatic test_window_restart();
      for (int i = 0; i < 9; i++) send_char(gkdm_pkg::CHAR_A, i == 0);
      send_char(8'hFF, 1'b0);          // junk character empties the window
      repeat (2) send_char(gkdm_pkg::CHAR_A, 1'b0);
      // segment start mid-stream: ten more bases needed before the hit
      for (int i = 0; i < 10; i++) send_char(gkdm_pkg::CHAR_A, i == 0);
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_words);
      int             stop_at;
      int             pick;
      logic [ECW-1:0] code;
      logic           seg;
      stop_at       = words_sent + n_words;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_load(ECW'($urandom_range(20'hFFFFF)), BCW'($urandom_range(255)),
                      1'($urandom_range(1)));
         end else if (pick < 25) begin
            if ($urandom_range(1) != 0)
               send_char(BCW'($urandom_range(255)), $urandom_range(3) == 0);
            else
               send_char(char_of_base(2'($urandom_range(3))), $urandom_range(3) == 0);
         end else begin
            // known k-mer behind a few stray bases; now and then one base altered
            code = dict_codes[$urandom_range(dict_codes.size() - 1)];
            if ($urandom_range(7) == 0)
               code[2 * $urandom_range(KMER_LEN - 1) +: 2] = 2'($urandom_range(3));
            seg = ($urandom_range(3) == 0);
            repeat ($urandom_range(4)) begin
               send_char(char_of_base(2'($urandom_range(3))), seg);
               seg = 1'b0;
            end
            for (int i = KMER_LEN - 1; i >= 0; i--) begin
               send_char(char_of_base(code[2*i +: 2]), seg);
               seg = 1'b0;
            end
         end
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_dictionary_load();
      test_window_restart();
      test_random_traffic(20, 77, 350);
      test_random_traffic(77, 20, 350);
      test_random_traffic(0, 0, 350);
      finish_run();
   end

endmodule
